// ===== design/quadrant_walk_stepper_macros.svh =====
// assertion macros shared by the checker
`ifndef QUADRANT_WALK_STEPPER_MACROS_SVH
`define QUADRANT_WALK_STEPPER_MACROS_SVH

// implication checked at every clock edge outside reset
`define QWS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, also checked while reset is high
`define QWS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/qws_pkg.sv =====
package qws_pkg;

  typedef struct packed {
    logic        [31:0] right_threshold;
    logic signed [31:0] start_column;
    logic signed [31:0] exit_column;
    logic        [31:0] window_length;
  } qws_cfg_t;

  typedef struct packed {
    logic exited;
    logic window_end;
  } qws_flags_t;

  typedef enum logic [7:0] {
    REG_RIGHT_THRESHOLD = 8'd0,
    REG_START_COLUMN    = 8'd1,
    REG_EXIT_COLUMN     = 8'd2,
    REG_WINDOW_LENGTH   = 8'd3
  } qws_reg_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic        [31:0] RST_RIGHT_THRESHOLD = 32'd2147483647;
  localparam logic signed [31:0] RST_START_COLUMN    = -32'sd1;
  localparam logic signed [31:0] RST_EXIT_COLUMN     = 32'sd0;
  localparam logic        [31:0] RST_WINDOW_LENGTH   = 32'd1000;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_WEXITS_LSB = 63;
  localparam int OUT_WEXITS_MSB = 94;

endpackage

// ===== design/qws_step.sv =====
module qws_step import qws_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  qws_cfg_t                        cfg,
  input  logic                            action,
  input  logic        [31:0]              random_word,
  input  logic        [30:0]              restart_row,
  input  logic signed [31:0]              load_x,
  input  logic        [30:0]              load_y,
  input  logic signed [COORD_WIDTH-1:0]   walker_x,
  input  logic        [COORD_WIDTH-2:0]   walker_y,
  input  logic        [COUNT_WIDTH-1:0]   steps_in_window,
  input  logic        [COUNT_WIDTH-1:0]   exits_in_window,
  output logic signed [COORD_WIDTH-1:0]   walker_x_next,
  output logic        [COORD_WIDTH-2:0]   walker_y_next,
  output logic        [COUNT_WIDTH-1:0]   steps_in_window_next,
  output logic        [COUNT_WIDTH-1:0]   exits_in_window_next,
  output qws_flags_t                      flags,
  output logic        [31:0]              window_exits
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = COUNT_WIDTH;
  localparam int SW = (NW + 1 > 33) ? NW + 1 : 33;
  localparam logic signed [CW-1:0] X_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] X_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-2:0] Y_MAX = {(CW-1){1'b1}};
  localparam logic [NW-1:0] CNT_MAX = {NW{1'b1}};

  logic signed [CW-1:0] load_x_sat, start_x_sat, mx;
  logic        [CW-2:0] load_y_sat, restart_y_sat, my;
  logic        [31:0]   load_y32, restart_y32;
  logic signed [CW:0]   xe, neg_x, nx_e;
  logic                 right, up, hold, at_exit;
  logic signed [31:0]   mx32;
  logic        [NW:0]   steps;
  logic        [31:0]   len;
  logic                 wend;
  logic        [NW-1:0] exits_inc;

  // coordinate saturation
  always_comb begin
    load_y32    = {1'b0, load_y};
    restart_y32 = {1'b0, restart_row};
    if (load_x[31:CW-1] == {(33-CW){load_x[31]}}) begin
      load_x_sat = load_x[CW-1:0];
    end else begin
      load_x_sat = load_x[31] ? X_MIN : X_MAX;
    end
    if (cfg.start_column[31:CW-1] == {(33-CW){cfg.start_column[31]}}) begin
      start_x_sat = cfg.start_column[CW-1:0];
    end else begin
      start_x_sat = cfg.start_column[31] ? X_MIN : X_MAX;
    end
    load_y_sat    = (load_y32[31:CW-1] == '0) ? load_y32[CW-2:0] : Y_MAX;
    restart_y_sat = (restart_y32[31:CW-1] == '0) ? restart_y32[CW-2:0] : Y_MAX;
  end

  // one move
  always_comb begin
    right = cfg.right_threshold >= random_word;
    up    = random_word[0];
    xe    = {walker_x[CW-1], walker_x};
    neg_x = -xe;
    hold  = right && ((walker_y == '0 && up) || ({2'b00, walker_y} == neg_x && !up));
    nx_e  = right ? xe + (CW+1)'(1) : xe - (CW+1)'(1);
    mx = walker_x;
    my = walker_y;
    if (!hold) begin
      if (nx_e[CW] == nx_e[CW-1]) begin
        mx = nx_e[CW-1:0];
      end else begin
        mx = nx_e[CW] ? X_MIN : X_MAX;
      end
      if (right && up) begin
        my = (walker_y == '0) ? walker_y : walker_y - (CW-1)'(1);
      end else if (!right && !up) begin
        my = (walker_y == Y_MAX) ? walker_y : walker_y + (CW-1)'(1);
      end
    end
    mx32    = 32'(mx);
    at_exit = mx32 >= cfg.exit_column;
  end

  // window counting
  always_comb begin
    len   = (cfg.window_length == '0) ? 32'd1 : cfg.window_length;
    steps = {1'b0, steps_in_window} + (NW+1)'(1);
    wend  = (SW'(steps) >= SW'(len)) || (steps >= {1'b0, CNT_MAX});
    exits_inc = (at_exit && exits_in_window != CNT_MAX) ?
                exits_in_window + NW'(1) : exits_in_window;
  end

  always_comb begin
    walker_x_next        = walker_x;
    walker_y_next        = walker_y;
    steps_in_window_next = steps_in_window;
    exits_in_window_next = exits_in_window;
    flags                = '0;
    window_exits         = '0;
    if (action == ACT_LOAD) begin
      walker_x_next = load_x_sat;
      walker_y_next = load_y_sat;
    end else begin
      walker_x_next = at_exit ? start_x_sat : mx;
      walker_y_next = at_exit ? restart_y_sat : my;
      flags.exited  = at_exit;
      flags.window_end = wend;
      if (wend) begin
        window_exits         = 32'(exits_inc);
        steps_in_window_next = '0;
        exits_in_window_next = '0;
      end else begin
        steps_in_window_next = steps[NW-1:0];
        exits_in_window_next = exits_inc;
      end
    end
  end

endmodule

// ===== design/quadrant_walk_stepper.sv =====
// channel  dir  handshake        payload
// s_       in   tvalid/tready    tuser action, tdata step and load fields
// m_       out  tvalid/tready    tuser exited, tlast window end, tdata position, exits
// cfg_     in   valid/ready      index, data
// one word per cycle while s_tready is high: the walker step is computed from
// the input word and the walker registers and lands in the output register at acceptance
// result appears in the cycle after acceptance; s_tready is low only while a
// result waits and m_tready is low
// synchronous reset: walker at (-1, 0), counters zero, registers at defaults
// cfg_ready is always high
module quadrant_walk_stepper import qws_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   s_tuser,   // action
  // random_word[31:0], restart_row[62:32], load_x[94:63], load_y[125:95]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic                   m_tlast,
  output logic                   m_tuser,   // exited
  // pos_x[31:0], pos_y[62:32], window_exits[94:63]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  qws_cfg_t                      cfg;
  logic signed [COORD_WIDTH-1:0] walker_x, walker_x_next;
  logic        [COORD_WIDTH-2:0] walker_y, walker_y_next;
  logic        [COUNT_WIDTH-1:0] steps_in_window, steps_in_window_next;
  logic        [COUNT_WIDTH-1:0] exits_in_window, exits_in_window_next;
  qws_flags_t                    flags;
  logic        [31:0]            window_exits;
  logic                          accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  qws_step #(
    .COORD_WIDTH (COORD_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg                  (cfg),
    .action               (s_tuser),
    .random_word          (s_tdata[31:0]),
    .restart_row          (s_tdata[62:32]),
    .load_x               (s_tdata[94:63]),
    .load_y               (s_tdata[125:95]),
    .walker_x             (walker_x),
    .walker_y             (walker_y),
    .steps_in_window      (steps_in_window),
    .exits_in_window      (exits_in_window),
    .walker_x_next        (walker_x_next),
    .walker_y_next        (walker_y_next),
    .steps_in_window_next (steps_in_window_next),
    .exits_in_window_next (exits_in_window_next),
    .flags                (flags),
    .window_exits         (window_exits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_threshold <= RST_RIGHT_THRESHOLD;
      cfg.start_column    <= RST_START_COLUMN;
      cfg.exit_column     <= RST_EXIT_COLUMN;
      cfg.window_length   <= RST_WINDOW_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RIGHT_THRESHOLD: cfg.right_threshold <= cfg_data;
        REG_START_COLUMN:    cfg.start_column    <= cfg_data;
        REG_EXIT_COLUMN:     cfg.exit_column     <= cfg_data;
        REG_WINDOW_LENGTH:   cfg.window_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walker_x        <= '1;
      walker_y        <= '0;
      steps_in_window <= '0;
      exits_in_window <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (accept) begin
        walker_x        <= walker_x_next;
        walker_y        <= walker_y_next;
        steps_in_window <= steps_in_window_next;
        exits_in_window <= exits_in_window_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, window_exits, 31'(walker_y_next), 32'(walker_x_next)};
      m_tuser <= flags.exited;
      m_tlast <= flags.window_end;
    end
  end

endmodule

// ===== design/qws_checker.sv =====
`include "quadrant_walk_stepper_macros.svh"

module qws_checker import qws_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic                   m_tlast,
  input logic                   m_tuser,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  `QWS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
  `QWS_ASSERT(a_accept_result, clk, rst, s_tvalid && s_tready |=> m_tvalid, "accepted word gave no result")
  `QWS_ASSERT(a_load_quiet, clk, rst, s_tvalid && s_tready && s_tuser == ACT_LOAD |=> !m_tuser && !m_tlast && m_tdata[OUT_WEXITS_MSB:OUT_WEXITS_LSB] == '0, "load reported exit or window")
  `QWS_ASSERT(a_exits_only_at_end, clk, rst, m_tvalid && !m_tlast |-> m_tdata[OUT_WEXITS_MSB:OUT_WEXITS_LSB] == '0, "exit total outside window end")
  `QWS_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready, "not ready with empty output")

endmodule

bind quadrant_walk_stepper qws_checker u_qws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
module tb;
  import qws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint X_MAX = 64'sd2147483647;
  localparam longint X_MIN = -64'sd2147483648;
  localparam longint CNT_MAX = 64'sd4294967295;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [30:0] pos_y;
    logic        exited;
    logic        window_end;
    logic [31:0] window_exits;
  } walk_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic                   s_tuser;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   m_tlast;
  logic                   m_tuser;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_index;
  logic [31:0]            cfg_data;

  quadrant_walk_stepper uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qws_cfg_t     cfg_shadow;
  longint       wk_x;
  longint       wk_y;
  longint       win_steps;
  longint       win_exits;
  walk_result_t expected_walks[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           src_gap_en = 1'b1;
  bit           sink_stall_en = 1'b1;
  bit           sink_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // walker state update for one accepted word
  task automatic advance_walker(input logic act, input logic [31:0] word,
                                input logic [30:0] row, input logic signed [31:0] lx,
                                input logic [30:0] ly);
    walk_result_t r;
    logic         right;
    logic         up;
    logic         hold;
    longint       nx;
    longint       ny;
    longint       len;
    r = '0;
    if (act == ACT_LOAD) begin
      wk_x = longint'(lx);
      wk_y = longint'({33'd0, ly});
    end else begin
      right = cfg_shadow.right_threshold >= word;
      up = word[0];
      hold = right && ((wk_y == 0 && up) || (wk_y == -wk_x && !up));
      if (!hold) begin
        nx = right ? wk_x + 1 : wk_x - 1;
        ny = wk_y;
        if (right && up) ny = ny - 1;
        if (!right && !up) ny = ny + 1;
        wk_x = (nx < X_MIN) ? X_MIN : (nx > X_MAX) ? X_MAX : nx;
        wk_y = (ny < 0) ? 0 : (ny > X_MAX) ? X_MAX : ny;
      end
      if (wk_x >= longint'(signed'(cfg_shadow.exit_column))) begin
        wk_x = longint'(signed'(cfg_shadow.start_column));
        wk_y = longint'({33'd0, row});
        r.exited = 1'b1;
        if (win_exits < CNT_MAX) win_exits = win_exits + 1;
      end
      len = (cfg_shadow.window_length == 0) ? 1 : longint'({32'd0, cfg_shadow.window_length});
      win_steps = win_steps + 1;
      if (win_steps >= len || win_steps >= CNT_MAX) begin
        r.window_end = 1'b1;
        r.window_exits = win_exits[31:0];
        win_steps = 0;
        win_exits = 0;
      end
    end
    r.pos_x = wk_x[31:0];
    r.pos_y = wk_y[30:0];
    expected_walks = {expected_walks, r};
  endtask

  task automatic send_item(input logic act, input logic [31:0] word, input logic [30:0] row,
                           input logic [31:0] lx, input logic [30:0] ly);
    if (src_gap_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {2'b00, ly, lx, row, word};
    do @(posedge clk); while (!s_tready);
    advance_walker(act, word, row, lx, ly);
  endtask

  task automatic step(input logic [31:0] word, input logic [30:0] row);
    send_item(ACT_STEP, word, row, $urandom, 31'($urandom));
  endtask

  task automatic place(input logic [31:0] lx, input logic [30:0] ly);
    send_item(ACT_LOAD, $urandom, 31'($urandom), lx, ly);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input qws_cfg_t c);
    qws_reg_t    idx;
    logic [31:0] val;
    settle();
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        REG_RIGHT_THRESHOLD: val = c.right_threshold;
        REG_START_COLUMN:    val = c.start_column;
        REG_EXIT_COLUMN:     val = c.exit_column;
        default:             val = c.window_length;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic test_reset_state();
    step(32'h0000_0000, 31'd0);
    step(32'hFFFF_FFFF, 31'd0);
    step(RST_RIGHT_THRESHOLD, 31'd0);
    step(RST_RIGHT_THRESHOLD + 32'd1, 31'd0);
    step(32'h0000_0002, 31'h7FFF_FFFF);
  endtask

  task automatic test_edges_and_holds();
    qws_cfg_t c;
    c.right_threshold = RST_RIGHT_THRESHOLD;
    c.start_column = RST_START_COLUMN;
    c.exit_column = RST_EXIT_COLUMN;
    c.window_length = 32'd4;
    apply_settings(c);
    place(32'h8000_0000, 31'd0);
    step(32'hFFFF_FFFE, 31'd3);
    place(32'h8000_0000, 31'h7FFF_FFFF);
    step(32'hFFFF_FFFE, 31'd3);
    place(32'h7FFF_FFFF, 31'd0);
    step(32'h0000_0000, 31'h7FFF_FFFF);
    place(-32'sd5, 31'd5);
    step(32'h0000_0002, 31'd0);
    place(-32'sd3, 31'd10);
    step(32'h0000_0001, 31'd0);
    place(32'h0000_0000, 31'd0);
    step(32'hFFFF_FFFF, 31'd1);
  endtask

  task automatic test_zero_window();
    qws_cfg_t c;
    c.right_threshold = 32'hFFFF_FFFF;
    c.start_column = -32'sd2;
    c.exit_column = RST_EXIT_COLUMN;
    c.window_length = 32'd0;
    apply_settings(c);
    repeat (3) step($urandom, 31'd1);
  endtask

  task automatic test_column_extremes();
    qws_cfg_t c;
    c.right_threshold = 32'h0000_0000;
    c.start_column = 32'h8000_0000;
    c.exit_column = -32'sd2147483647;
    c.window_length = 32'hFFFF_FFFF;
    apply_settings(c);
    place(32'h8000_0000, 31'd0);
    step(32'h0000_0000, 31'd0);
    step(32'h0000_0001, 31'd7);
    step(32'h0000_0000, 31'd0);
  endtask

  task automatic test_backpressure();
    bit gaps_saved;
    gaps_saved = src_gap_en;
    settle();
    src_gap_en = 1'b0;
    sink_hold_req = 1'b1;
    repeat (40) step($urandom, 31'($urandom_range(0, 1)));
    src_gap_en = gaps_saved;
  endtask

  task automatic test_random_walks(input int phases, input int per_phase);
    qws_cfg_t c;
    int       span;
    int       off;
    int       lspan;
    bit       noisy;
    for (int ph = 0; ph < phases; ph++) begin
      src_gap_en = (ph != phases - 1);
      sink_stall_en = (ph != phases - 1);
      span = $urandom_range(1, 20);
      off = $urandom_range(1, span);
      c.right_threshold = ($urandom_range(0, 3) == 0) ? $urandom :
                          32'h8000_0000 + $urandom_range(0, 32'h4000_0000);
      c.start_column = -span;
      c.exit_column = off - span;
      c.window_length = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 40);
      apply_settings(c);
      repeat (per_phase) begin
        noisy = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 11) == 0) begin
          lspan = $urandom_range(0, 30);
          if (noisy) place($urandom, 31'($urandom));
          else place(-lspan, 31'($urandom_range(0, lspan)));
        end else begin
          step($urandom, noisy ? 31'($urandom) : 31'($urandom_range(0, span)));
        end
      end
    end
  endtask

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    walk_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_walks.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d", $time, $signed(m_tdata[31:0]),
                 m_tdata[62:32]);
        mismatch_count++;
      end else begin
        e = expected_walks.pop_front();
        if (m_tdata[31:0] !== e.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, $signed(e.pos_x),
                   $signed(m_tdata[31:0]));
          mismatch_count++;
        end
        if (m_tdata[62:32] !== e.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, m_tdata[62:32]);
          mismatch_count++;
        end
        if (m_tuser !== e.exited) begin
          $display("%0t: exited expected %0b actual %0b", $time, e.exited, m_tuser);
          mismatch_count++;
        end
        if (m_tlast !== e.window_end) begin
          $display("%0t: window_end expected %0b actual %0b", $time, e.window_end, m_tlast);
          mismatch_count++;
        end
        if (m_tdata[OUT_WEXITS_MSB:OUT_WEXITS_LSB] !== e.window_exits) begin
          $display("%0t: window_exits expected %0d actual %0d", $time, e.window_exits,
                   m_tdata[OUT_WEXITS_MSB:OUT_WEXITS_LSB]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = ACT_LOAD;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RIGHT_THRESHOLD;
    cfg_data = '0;
    cfg_shadow.right_threshold = RST_RIGHT_THRESHOLD;
    cfg_shadow.start_column = RST_START_COLUMN;
    cfg_shadow.exit_column = RST_EXIT_COLUMN;
    cfg_shadow.window_length = RST_WINDOW_LENGTH;
    wk_x = -1;
    wk_y = 0;
    win_steps = 0;
    win_exits = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_edges_and_holds();
    test_zero_window();
    test_column_extremes();
    test_backpressure();
    test_random_walks(7, 250);
    settle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
